@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
// no dependencies; users supply clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition that must never be seen
`define CBP_NEVER(label, cond, msg) \
    `CBP_ASSERT(label, !(cond), msg)

`endif

@@ rtl/cbp_pkg.sv @@
// shared types and constants for the cube broadcast peer block
// no dependencies
`timescale 1ns / 1ps

package cbp_pkg;

    localparam int RANK_BITS = 16;
    localparam int COUNT_W   = RANK_BITS + 1;
    localparam int RADIX_W   = 11;
    localparam int IDX_W     = $clog2(RANK_BITS);
    localparam int PROD_W    = RANK_BITS + RADIX_W;
    localparam int KIND_W    = 2;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT     = {1'b1, {RANK_BITS{1'b0}}};
    localparam logic [COUNT_W-1:0] RANK_COUNT_RST  = COUNT_W'(1);
    localparam logic [RADIX_W-1:0] CUBE_RADIX_RST  = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MIN       = RADIX_W'(2);

    // register index taken from paddr[2]
    localparam logic REG_RANK_COUNT = 1'b0;
    localparam logic REG_CUBE_RADIX = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_RECV = 2'd0,
        KIND_SEND = 2'd1,
        KIND_NONE = 2'd2,
        KIND_ERR  = 2'd3
    } peer_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BUILD,
        ST_WALK,
        ST_DIV,
        ST_RECV,
        ST_SUCC,
        ST_LOWER,
        ST_FINISH
    } cbp_state_t;

    typedef struct packed {
        logic load;
        logic emit_err;
        logic build_step;
        logic take_top;
        logic div_start;
        logic digit_take;
        logic try_recv;
        logic try_succ;
        logic try_lower;
        logic finish;
    } cbp_cmd_t;

    typedef struct packed {
        logic rank_oor;
        logic build_more;
        logic at_top;
        logic div_done;
        logic rem_zero;
        logic idx_zero;
    } cbp_stat_t;

endpackage

@@ rtl/cbp_cfg.sv @@
// apb register file holding rank_count and cube_radix
// depends on cbp_pkg
`timescale 1ns / 1ps

module cbp_cfg import cbp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    output logic [COUNT_W-1:0] rank_count,
    output logic [RADIX_W-1:0] cube_radix
);

    logic               wr_en;
    logic [COUNT_W-1:0] rank_count_reg;
    logic [RADIX_W-1:0] cube_radix_reg;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_count_reg <= RANK_COUNT_RST;
            cube_radix_reg <= CUBE_RADIX_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_RANK_COUNT: rank_count_reg <= pwdata[COUNT_W-1:0];
                REG_CUBE_RADIX: cube_radix_reg <= pwdata[RADIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_RANK_COUNT: prdata = APB_DW'(rank_count_reg);
            REG_CUBE_RADIX: prdata = APB_DW'(cube_radix_reg);
            default:        prdata = '0;
        endcase
    end

    assign rank_count = rank_count_reg;
    assign cube_radix = cube_radix_reg;

endmodule

@@ rtl/cbp_div.sv @@
// restoring divider, one quotient bit per cycle, for rank digits by the radix
// depends on cbp_pkg
`timescale 1ns / 1ps

module cbp_div import cbp_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RANK_BITS-1:0] dividend,
    input  logic [RADIX_W-1:0]   divisor,
    output logic                 done,
    output logic [RANK_BITS-1:0] quotient,
    output logic [RADIX_W-1:0]   remainder
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic [RANK_BITS-1:0] quo_reg;
    logic [RADIX_W-1:0]   rem_reg;
    logic [RADIX_W:0]     rem_sh;
    logic [RADIX_W:0]     rem_sub;
    logic                 fits;

    assign rem_sh  = {rem_reg, quo_reg[RANK_BITS-1]};
    assign fits    = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= IDX_W'(RANK_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[RANK_BITS-2:0], fits};
            rem_reg <= fits ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/cbp_dp.sv @@
// datapath: radix power table, digit walk, peer candidates and result register
// depends on cbp_pkg and cbp_div
`timescale 1ns / 1ps

module cbp_dp import cbp_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cbp_cmd_t             cmd,
    output cbp_stat_t            stat,
    input  logic [RANK_BITS-1:0] local_rank,
    input  logic [COUNT_W-1:0]   rank_count,
    input  logic [RADIX_W-1:0]   cube_radix,
    output logic                 result_valid,
    output logic [KIND_W-1:0]    peer_kind,
    output logic [RANK_BITS-1:0] peer_rank,
    output logic                 last_peer
);

    logic [RANK_BITS-1:0] rank_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [RADIX_W-1:0]   radix_reg;
    logic [RANK_BITS-1:0] pow_reg [RANK_BITS];
    logic [IDX_W-1:0]     top_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [RANK_BITS-1:0] q_reg;
    logic [RADIX_W-1:0]   pos_reg;

    logic                 pend_valid_reg;
    peer_kind_t           pend_kind_reg;
    logic [RANK_BITS-1:0] pend_peer_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    peer_kind_t           out_kind_reg;
    logic [RANK_BITS-1:0] out_peer_reg;
    logic                 out_last_reg;

    logic [COUNT_W-1:0]   count_sat;
    logic [RADIX_W-1:0]   radix_eff;
    logic [RANK_BITS-1:0] pow_cur;
    logic [PROD_W-1:0]    prod;
    logic [COUNT_W-1:0]   m_full;
    logic [COUNT_W-1:0]   sum;
    logic                 below;
    logic [RADIX_W-1:0]   radix_m1;
    logic                 cand;
    peer_kind_t           cand_kind;
    logic [RANK_BITS-1:0] cand_peer;

    logic                 div_done;
    logic [RANK_BITS-1:0] div_quo;
    logic [RADIX_W-1:0]   div_rem;

    cbp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (q_reg),
        .divisor   (radix_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign count_sat = (rank_count > COUNT_LIMIT) ? COUNT_LIMIT : rank_count;
    assign radix_eff = (cube_radix < RADIX_MIN) ? RADIX_MIN : cube_radix;

    assign pow_cur  = pow_reg[idx_reg];
    assign prod     = PROD_W'(pow_cur) * PROD_W'(radix_reg);
    assign m_full   = count_reg - COUNT_W'(1);
    assign sum      = {1'b0, rank_reg} + {1'b0, pow_cur};
    assign below    = sum < count_reg;
    assign radix_m1 = radix_reg - RADIX_W'(1);

    // a peer found in this cycle
    assign cand = (cmd.try_recv && (rank_reg != '0))
               || (cmd.try_succ && (pos_reg < radix_m1) && below)
               || (cmd.try_lower && below);
    assign cand_kind = cmd.try_recv ? KIND_RECV : KIND_SEND;
    assign cand_peer = cmd.try_recv ? (rank_reg - pow_cur) : sum[RANK_BITS-1:0];

    always_comb
    begin
        stat.rank_oor   = {1'b0, rank_reg} >= count_reg;
        stat.build_more = (prod <= PROD_W'(m_full[RANK_BITS-1:0]))
                       && (idx_reg != IDX_W'(RANK_BITS - 1));
        stat.at_top     = idx_reg == top_reg;
        stat.div_done   = div_done;
        stat.rem_zero   = div_rem == '0;
        stat.idx_zero   = idx_reg == '0;
    end

    // working registers of one request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rank_reg   <= local_rank;
            count_reg  <= count_sat;
            radix_reg  <= radix_eff;
            pow_reg[0] <= RANK_BITS'(1);
            idx_reg    <= '0;
        end
        else if (cmd.build_step)
        begin
            if (stat.build_more)
            begin
                pow_reg[idx_reg + IDX_W'(1)] <= prod[RANK_BITS-1:0];
                idx_reg <= idx_reg + IDX_W'(1);
            end
            else
            begin
                top_reg <= idx_reg;
                idx_reg <= '0;
                q_reg   <= rank_reg;
            end
        end
        else if (cmd.take_top)
        begin
            // quotient at the top dimension is already below the radix
            pos_reg <= RADIX_W'(q_reg);
        end
        else if (cmd.digit_take)
        begin
            if (stat.rem_zero)
            begin
                q_reg   <= div_quo;
                idx_reg <= idx_reg + IDX_W'(1);
            end
            else
            begin
                pos_reg <= div_rem;
            end
        end
        else if (cmd.try_succ || cmd.try_lower)
        begin
            if (!stat.idx_zero)
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    // one peer is held back so that the last one can be marked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.load)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cand)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    assign out_valid_next = (cand && pend_valid_reg) || cmd.finish || cmd.emit_err;

    always_ff @(posedge clk)
    begin
        if (cand)
        begin
            pend_kind_reg <= cand_kind;
            pend_peer_reg <= cand_peer;
        end
        if (cmd.emit_err)
        begin
            out_kind_reg <= KIND_ERR;
            out_peer_reg <= '0;
            out_last_reg <= 1'b1;
        end
        else if (cmd.finish)
        begin
            out_kind_reg <= pend_valid_reg ? pend_kind_reg : KIND_NONE;
            out_peer_reg <= pend_valid_reg ? pend_peer_reg : '0;
            out_last_reg <= 1'b1;
        end
        else if (cand)
        begin
            out_kind_reg <= pend_kind_reg;
            out_peer_reg <= pend_peer_reg;
            out_last_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign peer_kind    = out_kind_reg;
    assign peer_rank    = out_peer_reg;
    assign last_peer    = out_last_reg;

endmodule

@@ rtl/cbp_ctrl.sv @@
// controller state machine sequencing one rank request through the datapath
// depends on cbp_pkg
`timescale 1ns / 1ps

module cbp_ctrl import cbp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  cbp_stat_t stat,
    output cbp_cmd_t  cmd
);

    cbp_state_t state_reg;
    cbp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:  state_next = stat.rank_oor ? ST_IDLE : ST_BUILD;
            ST_BUILD:
            begin
                if (!stat.build_more)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:   state_next = stat.at_top ? ST_RECV : ST_DIV;
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.rem_zero ? ST_WALK : ST_RECV;
                end
            end
            ST_RECV:   state_next = ST_SUCC;
            ST_SUCC:   state_next = stat.idx_zero ? ST_FINISH : ST_LOWER;
            ST_LOWER:
            begin
                if (stat.idx_zero)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.load       = start;
            ST_CHECK:  cmd.emit_err   = stat.rank_oor;
            ST_BUILD:  cmd.build_step = 1'b1;
            ST_WALK:
            begin
                cmd.take_top  = stat.at_top;
                cmd.div_start = !stat.at_top;
            end
            ST_DIV:    cmd.digit_take = stat.div_done;
            ST_RECV:   cmd.try_recv   = 1'b1;
            ST_SUCC:   cmd.try_succ   = 1'b1;
            ST_LOWER:  cmd.try_lower  = 1'b1;
            ST_FINISH: cmd.finish     = 1'b1;
            default:   cmd = '0;
        endcase
    end

    assign busy = state_reg != ST_IDLE;

endmodule

@@ rtl/cube_broadcast_peers.sv @@
// channel   | signals                                        | handshake
// request   | start, local_rank                              | taken when start and not busy
// result    | result_valid, peer_kind, peer_rank, last_peer  | one-cycle strobe, no back-pressure
// config    | psel, penable, pwrite, paddr, pwdata, ...      | apb, pready tied high
//
// a request runs alone: a check, one build step per cube dimension for the radix powers,
// a divide per low base-radix digit up to the first non-zero one (none once the top
// dimension is reached), then receive, successor, every lower dimension and finish; an
// out-of-range rank ends after the check. a found peer waits in a pending register and leaves
// through the output register when the next is found or at finish; a new request is taken in
// the cycle that shows the final result; asynchronous active-low reset, count 1, radix 2
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cube_broadcast_peers import cbp_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [RANK_BITS-1:0] local_rank,
    output logic                 result_valid,
    output logic [KIND_W-1:0]    peer_kind,
    output logic [RANK_BITS-1:0] peer_rank,
    output logic                 last_peer,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    logic [COUNT_W-1:0] rank_count;
    logic [RADIX_W-1:0] cube_radix;
    cbp_cmd_t           cmd;
    cbp_stat_t          stat;

    cbp_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .rank_count (rank_count),
        .cube_radix (cube_radix)
    );

    cbp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    cbp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .local_rank   (local_rank),
        .rank_count   (rank_count),
        .cube_radix   (cube_radix),
        .result_valid (result_valid),
        .peer_kind    (peer_kind),
        .peer_rank    (peer_rank),
        .last_peer    (last_peer)
    );

    `CBP_ASSERT(a_accept_quiet, start && !busy |=> !result_valid, "result right after accept")
    `CBP_ASSERT(a_last_gap, result_valid && last_peer |=> !result_valid, "result after last")
    `CBP_ASSERT(a_more_busy, result_valid && !last_peer |-> busy, "idle before last result")
    `CBP_NEVER(a_single_last,
        result_valid && (peer_kind == KIND_NONE || peer_kind == KIND_ERR) && !last_peer,
        "none or error result not marked last")

endmodule

@@ tb/tb_cube_broadcast_peers.sv @@
// self-checking testbench for cube_broadcast_peers: directed and random rank queries
// under several count/radix settings. depends on cbp_pkg and the rtl only
`timescale 1ns / 1ps

module tb_cube_broadcast_peers;
    import cbp_pkg::*;

    localparam int MAX_PEERS   = 17;
    localparam int SETTLE_CYC  = 400;
    localparam int RAND_PHASES = 10;
    localparam int RAND_ITEMS  = 47;

    typedef struct {
        peer_kind_t           kind;
        logic [RANK_BITS-1:0] peer;
        logic                 last;
    } peer_result_t;

    // holds the peer list each accepted rank should produce, in order
    class cube_peer_board;
        logic [COUNT_W-1:0] rank_count;
        logic [RADIX_W-1:0] cube_radix;
        peer_result_t       pending_peers[$];
        int                 mismatches;

        function new();
            rank_count  = RANK_COUNT_RST;
            cube_radix  = CUBE_RADIX_RST;
            mismatches  = 0;
        endfunction

        function void set_register(logic reg_idx, logic [APB_DW-1:0] value);
            if (reg_idx == REG_RANK_COUNT)
                rank_count = value[COUNT_W-1:0];
            else
                cube_radix = value[RADIX_W-1:0];
        endfunction

        function void push_peer(peer_kind_t kind, longint unsigned peer, logic last);
            peer_result_t item;
            item.kind = kind;
            item.peer = peer[RANK_BITS-1:0];
            item.last = last;
            pending_peers = {pending_peers, item};
        endfunction

        // works out receive source and forward targets for one rank
        function void note_rank(logic [RANK_BITS-1:0] rank);
            longint unsigned cnt;
            longint unsigned rdx;
            longint unsigned m;
            longint unsigned stride;
            longint unsigned pos;
            longint unsigned r;
            peer_kind_t      kinds[$];
            longint unsigned peers[$];
            int              dims;
            int              depth;
            int              d;
            int              n;
            r   = rank;
            cnt = rank_count;
            if (cnt > COUNT_LIMIT)
                cnt = COUNT_LIMIT;
            rdx = (cube_radix < RADIX_MIN) ? RADIX_MIN : cube_radix;
            if (r >= cnt) begin
                push_peer(KIND_ERR, 0, 1'b1);
                return;
            end
            dims = 1;
            m = (cnt - 1) / rdx;
            while (m > 0) begin
                dims++;
                m = m / rdx;
            end
            stride = 1;
            for (d = 1; d < dims; d++)
                stride = stride * rdx;
            depth = 0;
            while (stride > 1 && (r % stride) != 0) begin
                depth++;
                stride = stride / rdx;
            end
            pos = (r % (stride * rdx)) / stride;
            if (r != 0) begin
                kinds = {kinds, KIND_RECV};
                peers = {peers, r - stride};
            end
            if (pos < rdx - 1 && r + stride < cnt) begin
                kinds = {kinds, KIND_SEND};
                peers = {peers, r + stride};
            end
            for (d = depth + 1; d < dims; d++) begin
                stride = stride / rdx;
                if (r + stride < cnt) begin
                    kinds = {kinds, KIND_SEND};
                    peers = {peers, r + stride};
                end
            end
            if (kinds.size() == 0) begin
                push_peer(KIND_NONE, 0, 1'b1);
                return;
            end
            n = (kinds.size() > MAX_PEERS) ? MAX_PEERS : kinds.size();
            for (d = 0; d < n; d++)
                push_peer(kinds[d], peers[d], d == n - 1);
        endfunction

        function void report(string what, peer_result_t want, logic [KIND_W-1:0] kind,
                             logic [RANK_BITS-1:0] peer, logic last);
            if (mismatches < 10)
                $display("%0t: %s: kind %0d/%0d peer %0d/%0d last %0b/%0b (exp/got)",
                         $realtime, what, want.kind, kind, want.peer, peer, want.last, last);
            mismatches++;
        endfunction

        function void check_peer(logic [KIND_W-1:0] kind, logic [RANK_BITS-1:0] peer,
                                 logic last);
            peer_result_t want;
            if (pending_peers.size() == 0) begin
                want.kind = KIND_NONE;
                want.peer = '0;
                want.last = 1'b0;
                report("result with no request pending", want, kind, peer, last);
                return;
            end
            want = pending_peers.pop_front();
            if (kind !== want.kind || peer !== want.peer || last !== want.last)
                report("peer mismatch", want, kind, peer, last);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [RANK_BITS-1:0] local_rank;
    logic                 result_valid;
    logic [KIND_W-1:0]    peer_kind;
    logic [RANK_BITS-1:0] peer_rank;
    logic                 last_peer;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    cube_peer_board board;
    int             burst_left;

    cube_broadcast_peers u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .local_rank   (local_rank),
        .result_valid (result_valid),
        .peer_kind    (peer_kind),
        .peer_rank    (peer_rank),
        .last_peer    (last_peer),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                board.check_peer(peer_kind, peer_rank, last_peer);
            if (start && !busy)
                board.note_rank(local_rank);
        end
    end

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int sel;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            burst_left = $urandom_range(5, 20);
        sel = $urandom_range(0, 19);
        if (sel < 10)
            return 0;
        else if (sel < 17)
            return $urandom_range(1, 4);
        else
            return $urandom_range(8, 250);
    endfunction

    task automatic send_rank(logic [RANK_BITS-1:0] rank);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        local_rank <= rank;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (busy || board.pending_peers.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic reg_idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.set_register(reg_idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [APB_DW-1:0] count_val, logic [APB_DW-1:0] radix_val);
        wait_idle();
        write_reg(REG_RANK_COUNT, count_val);
        @(posedge clk);
        write_reg(REG_CUBE_RADIX, radix_val);
        @(posedge clk);
    endtask

    // mostly in-range ranks, many of them aligned to a power of the radix
    function automatic logic [RANK_BITS-1:0] pick_rank(int unsigned eff_cnt,
                                                       int unsigned eff_rdx);
        int unsigned r;
        int unsigned p;
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel == 0 || eff_cnt == 0)
            return RANK_BITS'($urandom());
        if (sel == 1)
            return eff_cnt[RANK_BITS-1:0];
        r = $urandom_range(0, eff_cnt - 1);
        if (sel >= 7)
        begin
            p = 1;
            repeat ($urandom_range(1, 4))
                if (p * eff_rdx <= 65536)
                    p = p * eff_rdx;
            r = r - r % p;
        end
        return r[RANK_BITS-1:0];
    endfunction

    initial
    begin
        int unsigned cnt_val;
        int unsigned rdx_val;
        int unsigned eff_cnt;
        int unsigned eff_rdx;
        logic [APB_DW-1:0] cnt_word;
        logic [APB_DW-1:0] rdx_word;
        board      = new();
        burst_left = 0;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        local_rank <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: only rank 0 is in range and it has no peers
        send_rank(16'd0);
        send_rank(16'd1);
        send_rank(16'hFFFF);

        // zero count, everything out of range
        set_config(32'd0, 32'd5);
        send_rank(16'd0);

        // full rank space in binary: the deepest walks
        set_config(32'd65536, 32'd2);
        send_rank(16'd0);
        send_rank(16'hFFFF);
        send_rank(16'h8000);
        send_rank(16'h5555);
        send_rank(16'hAAAA);

        // count above the rank space saturates, radix zero acts as two
        set_config(32'hFFFF_FFFF, 32'hFFFF_F800);
        send_rank(16'd0);
        send_rank(16'hFFFF);

        set_config(32'd1000, 32'd10);
        send_rank(16'd0);
        send_rank(16'd999);
        send_rank(16'd990);
        send_rank(16'd500);
        send_rank(16'd1000);

        // radix past its nominal range
        set_config(32'd70000, 32'd2047);
        send_rank(16'd0);
        send_rank(16'd2047);
        send_rank(16'd4094);
        send_rank(16'hFFFF);

        // radix one acts as two
        set_config(32'd5, 32'd1);
        send_rank(16'd0);
        send_rank(16'd3);
        send_rank(16'd4);

        set_config(32'd2, 32'd1024);
        send_rank(16'd0);
        send_rank(16'd1);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0: cnt_val = $urandom_range(1, 64);
                1: cnt_val = $urandom_range(65, 65536);
                2: cnt_val = 65536;
                3: cnt_val = $urandom_range(65537, 131071);
                4: cnt_val = $urandom_range(0, 1);
                default: cnt_val = $urandom_range(1, 4096);
            endcase
            case ($urandom_range(0, 3))
                0: rdx_val = $urandom_range(0, 3);
                1: rdx_val = $urandom_range(2, 16);
                2: rdx_val = $urandom_range(17, 2047);
                default: rdx_val = 2;
            endcase
            cnt_word = cnt_val;
            rdx_word = rdx_val;
            // junk above the register width must be dropped
            if ($urandom_range(0, 1))
                cnt_word = ($urandom() & ~32'h1FFFF) | cnt_val;
            if ($urandom_range(0, 1))
                rdx_word = ($urandom() & ~32'h7FF) | rdx_val;
            set_config(cnt_word, rdx_word);
            eff_cnt = (cnt_val > 65536) ? 65536 : cnt_val;
            eff_rdx = (rdx_val < 2) ? 2 : rdx_val;
            for (int i = 0; i < RAND_ITEMS; i++)
                send_rank(pick_rank(eff_cnt, eff_rdx));
        end

        wait_idle();
        repeat (SETTLE_CYC) @(posedge clk);
        if (board.mismatches == 0 && board.pending_peers.size() == 0)
            $display("PASS cube_broadcast_peers");
        else
            $display("FAIL cube_broadcast_peers");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("FAIL cube_broadcast_peers");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cbp_pkg.sv
rtl/cbp_cfg.sv
rtl/cbp_div.sv
rtl/cbp_dp.sv
rtl/cbp_ctrl.sv
rtl/cube_broadcast_peers.sv
tb/tb_cube_broadcast_peers.sv
